// ----- rtl/mtff_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes for the max-tree first-fit allocator.
// Depends on nothing; every other file of the block uses it.

package mtff_pkg;

    // Number of slots. It must be a power of two.
    localparam int MAX_SLOTS  = 1024;
    localparam int LEVELS     = $clog2(MAX_SLOTS);
    // A node number of the tree, leaves included (1 .. 2*MAX_SLOTS-1).
    localparam int NODE_W     = LEVELS + 1;
    // A memory row holds a sibling pair; row r holds nodes 2r and 2r+1.
    localparam int ROW_W      = LEVELS;
    localparam int AMT_W      = 32;
    localparam int ROW_DATA_W = 2 * AMT_W;
    localparam int SLOT_W     = 10;
    localparam int POS_W      = 11;
    localparam int ACTIVE_W   = 11;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1024);

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_DESCEND,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;         // item channel may accept a beat
        logic clear_step;   // zero one memory row
        logic read_root;    // root fits: start the descent at node 1
        logic no_fit;       // result position is zero
        logic descend_step; // choose a child of the current node
        logic update_step;  // write one row of the path and move up
        logic out_load;     // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_valid;
        logic item_op;
        logic slot_ok;
        logic clear_last;
        logic root_fit;
        logic last_level;
        logic grant;
        logic top_row;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/mtff_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the allocator: item input, result output and the
// configuration write channel. Depends on mtff_pkg.

interface mtff_item_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [mtff_pkg::SLOT_W-1:0]  slot_index;
    logic [mtff_pkg::AMT_W-1:0]   amount;

    modport source (output valid, output operation, output slot_index, output amount,
                    input ready);
    modport sink   (input valid, input operation, input slot_index, input amount,
                    output ready);
endinterface

interface mtff_result_if;
    logic                        valid;
    logic                        ready;
    logic [mtff_pkg::POS_W-1:0]  position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface mtff_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mtff_pkg::ACTIVE_W-1:0]  active_slots;

    modport source (output valid, output active_slots, input ready);
    modport sink   (input valid, input active_slots, output ready);
endinterface

// ----- rtl/mtff_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the allocator: sequences the clearing pass, the descent,
// the path update and the result beat. Depends on mtff_pkg.

module mtff_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  mtff_pkg::stat_t stat,
    output mtff_pkg::cmd_t  cmd
);
    import mtff_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_req_reg;
    logic   is_req_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            is_req_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_req_reg <= is_req_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        is_req_next = is_req_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.item_valid)
                begin
                    is_req_next = (stat.item_op == OP_REQUEST);
                    if (stat.item_op == OP_REQUEST)
                    begin
                        state_next = ST_ROOT;
                    end
                    else if (stat.slot_ok)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_ROOT:
            begin
                if (stat.root_fit)
                begin
                    cmd.read_root = 1'b1;
                    state_next    = ST_DESCEND;
                end
                else
                begin
                    cmd.no_fit = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_DESCEND:
            begin
                cmd.descend_step = 1'b1;
                if (stat.last_level)
                begin
                    state_next = stat.grant ? ST_UPDATE : ST_RESULT;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_step = 1'b1;
                if (stat.top_row)
                begin
                    state_next = is_req_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mtff_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the allocator: tree memory of sibling pairs, path registers,
// active-count register and output register. Depends on mtff_pkg, mtff_if.

module mtff_dp (
    input  logic            clk,
    input  logic            rst_n,
    mtff_item_if.sink       item,
    mtff_result_if.source   result,
    mtff_cfg_if.sink        cfg,
    input  mtff_pkg::cmd_t  cmd,
    output mtff_pkg::stat_t stat
);
    import mtff_pkg::*;

    logic [ROW_DATA_W-1:0] tree_mem [MAX_SLOTS];
    logic [ROW_DATA_W-1:0] rd_data_reg;

    logic [ROW_W-1:0]    clr_cnt_reg;
    logic [ROW_W-1:0]    clr_cnt_next;
    logic [ACTIVE_W-1:0] active_reg;
    logic [ACTIVE_W-1:0] active_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [POS_W-1:0]    out_pos_reg;
    logic [POS_W-1:0]    out_pos_next;

    logic [AMT_W-1:0]    amount_reg;
    logic [AMT_W-1:0]    amount_next;
    logic [NODE_W-1:0]   node_reg;
    logic [NODE_W-1:0]   node_next;
    logic [AMT_W-1:0]    value_reg;
    logic [AMT_W-1:0]    value_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;

    logic                accept;
    logic [NODE_W-1:0]   leaf_node;
    logic [AMT_W-1:0]    lo_val;
    logic [AMT_W-1:0]    hi_val;
    logic                left_fit;
    logic [NODE_W-1:0]   child;
    logic [AMT_W-1:0]    chosen;
    logic [ROW_W-1:0]    leaf_idx;
    logic                grant;
    logic [ROW_W-1:0]    up_row;
    logic [AMT_W-1:0]    sibling;
    logic [AMT_W-1:0]    parent_val;
    logic [ROW_DATA_W-1:0] up_data;

    logic                  mem_we;
    logic [ROW_W-1:0]      mem_waddr;
    logic [ROW_DATA_W-1:0] mem_wdata;
    logic                  mem_re;
    logic [ROW_W-1:0]      mem_raddr;

    assign accept    = cmd.take && item.valid;
    assign leaf_node = NODE_W'(MAX_SLOTS) + NODE_W'(item.slot_index);

    assign lo_val   = rd_data_reg[AMT_W-1:0];
    assign hi_val   = rd_data_reg[ROW_DATA_W-1:AMT_W];
    assign left_fit = (lo_val >= amount_reg);
    assign child    = {node_reg[NODE_W-2:0], ~left_fit};
    assign chosen   = left_fit ? lo_val : hi_val;
    assign leaf_idx = child[ROW_W-1:0];
    assign grant    = (32'(leaf_idx) < 32'(active_reg));

    // Update: the current node sits in row node_reg/2 next to its sibling.
    assign up_row     = ROW_W'(node_reg[NODE_W-1:1]);
    assign sibling    = node_reg[0] ? lo_val : hi_val;
    assign parent_val = (value_reg > sibling) ? value_reg : sibling;
    assign up_data    = node_reg[0] ? {value_reg, lo_val} : {hi_val, value_reg};

    assign stat.item_valid = item.valid;
    assign stat.item_op    = item.operation;
    assign stat.slot_ok    = (32'(item.slot_index) < 32'(MAX_SLOTS));
    assign stat.clear_last = (clr_cnt_reg == ROW_W'(MAX_SLOTS - 1));
    assign stat.root_fit   = (hi_val >= amount_reg);
    assign stat.last_level = node_reg[LEVELS-1];
    assign stat.grant      = grant;
    assign stat.top_row    = (up_row == '0);
    assign stat.out_free   = !out_valid_reg || result.ready;

    assign item.ready      = cmd.take;
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.position = out_pos_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = up_row;
        mem_wdata = up_data;
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.update_step)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        priority if (accept)
        begin
            mem_re    = 1'b1;
            mem_raddr = (item.operation == OP_REQUEST) ? '0
                                                       : ROW_W'(leaf_node[NODE_W-1:1]);
        end
        else if (cmd.read_root)
        begin
            mem_re    = 1'b1;
            mem_raddr = ROW_W'(node_reg);
        end
        else if (cmd.descend_step && !node_reg[LEVELS-1])
        begin
            mem_re    = 1'b1;
            mem_raddr = ROW_W'(child);
        end
        else if (cmd.update_step)
        begin
            mem_re    = 1'b1;
            mem_raddr = ROW_W'(node_reg[NODE_W-1:2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tree_mem[mem_raddr];
        end
    end

    always_comb
    begin
        amount_next = amount_reg;
        node_next   = node_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            amount_next = item.amount;
            value_next  = item.amount;
            node_next   = (item.operation == OP_REQUEST) ? NODE_W'(1) : leaf_node;
        end
        if (cmd.no_fit)
        begin
            pos_next = '0;
        end
        if (cmd.descend_step)
        begin
            node_next = child;
            if (node_reg[LEVELS-1])
            begin
                value_next = chosen - amount_reg;
                pos_next   = grant ? POS_W'(32'(leaf_idx) + 32'd1) : '0;
            end
        end
        if (cmd.update_step)
        begin
            node_next  = NODE_W'(up_row);
            value_next = parent_val;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg  <= amount_next;
        node_reg    <= node_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        out_pos_reg <= out_pos_next;
    end

    always_comb
    begin
        clr_cnt_next   = cmd.clear_step ? clr_cnt_reg + ROW_W'(1) : clr_cnt_reg;
        active_next    = (cfg.valid && cfg.ready) ? cfg.active_slots : active_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_pos_next   = out_pos_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            active_reg    <= ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/max_tree_first_fit_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the max-tree first-fit allocator: controller plus datapath.
// Depends on mtff_pkg, mtff_if, mtff_ctrl and mtff_dp.
//
// Usage:
//   item   : one beat per operation. A load writes amount as the capacity of
//            slot_index and returns nothing. A request finds the lowest slot
//            below active_slots whose capacity is at least amount, subtracts
//            amount from it and returns its 1-based position (0 if none fits).
//   result : one beat per request, carrying position.
//   cfg    : writes active_slots; always ready. Write only while idle.
// Flow: the tree sits in one memory of sibling-pair rows with one read and
//   one write port. A granted request passes through the accept, a root
//   check, a descent from the root to a leaf, an update of the path back up
//   to the root and a result step. A request that fits nowhere goes from
//   the root check straight to the result; one whose first fit lies past
//   active_slots skips the update. A load updates the path from its leaf up.
// Reset: a clearing pass zeroes the tree's MAX_SLOTS rows one row per cycle;
//   item is not ready during the pass.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and a new result waits until the register is free.

module max_tree_first_fit_allocator_top (
    input  logic          clk,
    input  logic          rst_n,
    mtff_item_if.sink     item,
    mtff_result_if.source result,
    mtff_cfg_if.sink      cfg
);
    import mtff_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mtff_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mtff_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

// ----- sim/mtff_allocator_checker.sv -----
`timescale 1ns / 1ps
// Checker for the max-tree first-fit allocator: watches the item, result and
// configuration channels, predicts each grant and compares. Depends on mtff_pkg and mtff_if.

module mtff_allocator_checker (
    input  logic          clk,
    input  logic          rst_n,
    mtff_item_if          item,
    mtff_result_if        result,
    mtff_cfg_if           cfg,
    output int            mismatches,
    output int            outstanding,
    output int            loads_seen,
    output int            grants_seen,
    output int            refusals_seen
);
    import mtff_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [AMT_W-1:0]    slot_cap [MAX_SLOTS];
    logic [ACTIVE_W-1:0] active_slots;
    logic [POS_W-1:0]    expected_pos [$];
    logic [POS_W-1:0]    want;

    // Lowest searched slot that can hold the amount; its capacity is reduced.
    function automatic logic [POS_W-1:0] grant_first_fit(input logic [AMT_W-1:0] need);
        int span;
        span = (int'(active_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(active_slots);
        for (int s = 0; s < span; s++)
        begin
            if (slot_cap[s] >= need)
            begin
                slot_cap[s] = slot_cap[s] - need;
                return POS_W'(s + 1);
            end
        end
        return '0;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_cap[s]) slot_cap[s] = '0;
            active_slots  = ACTIVE_RESET;
            expected_pos.delete();
            outstanding   = 0;
            mismatches    = 0;
            loads_seen    = 0;
            grants_seen   = 0;
            refusals_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                active_slots = cfg.active_slots;
            end
            // The result beat is matched before this edge's item is predicted,
            // so a new request can never be paired with an older result.
            if (result.valid && result.ready)
            begin
                if (expected_pos.size() == 0)
                begin
                    note_mismatch($sformatf("position %0d with no request waiting",
                                            result.position));
                end
                else
                begin
                    want = expected_pos.pop_front();
                    if (result.position !== want)
                    begin
                        note_mismatch($sformatf("position expected %0d, actual %0d",
                                                want, result.position));
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.operation == OP_LOAD)
                begin
                    if (int'(item.slot_index) < MAX_SLOTS)
                    begin
                        slot_cap[item.slot_index] = item.amount;
                    end
                    loads_seen++;
                end
                else
                begin
                    want = grant_first_fit(item.amount);
                    expected_pos.push_back(want);
                    if (want == '0) refusals_seen++;
                    else grants_seen++;
                end
            end
            outstanding = expected_pos.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, stimulus and the verdict.
// Depends on mtff_pkg, mtff_if, the allocator RTL and mtff_allocator_checker.

module testbench;
    import mtff_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 30;
    localparam int SEGMENTS     = 4;
    localparam int SEG_ITEMS    = 92;

    logic clk;
    logic rst_n;

    int mismatches;
    int outstanding;
    int loads_seen;
    int grants_seen;
    int refusals_seen;
    int tx_idle_pct;
    int rx_stall_pct;
    int settings_used;
    logic [ACTIVE_W-1:0] cur_active;

    mtff_item_if   item_ch ();
    mtff_result_if result_ch ();
    mtff_cfg_if    cfg_ch ();

    max_tree_first_fit_allocator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mtff_allocator_checker grant_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .loads_seen    (loads_seen),
        .grants_seen   (grants_seen),
        .refusals_seen (refusals_seen)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Result receiver: drops ready at random at the configured rate.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic [AMT_W-1:0] amt);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.slot_index <= slot;
        item_ch.amount     <= amt;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    // Holds the item channel quiet until every pending result has come back.
    task automatic wait_results(input int settle);
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.active_slots <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_active = value;
        settings_used++;
    endtask

    function automatic logic [ACTIVE_W-1:0] pick_active();
        case ($urandom_range(7))
            0:       return ACTIVE_W'(1);
            1:       return ACTIVE_W'(2);
            2:       return ACTIVE_W'(MAX_SLOTS);
            3:       return '1;
            4:       return ACTIVE_W'(MAX_SLOTS - 1);
            5:       return ACTIVE_W'($urandom_range(3, 64));
            default: return ACTIVE_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Slots are drawn mostly from the searched range and just past it, so
    // loads and requests keep meeting each other.
    task automatic send_random_item();
        logic             op;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amt;
        int               span;
        span = (int'(cur_active) > MAX_SLOTS) ? MAX_SLOTS : int'(cur_active);
        op = ($urandom_range(99) < 55) ? OP_REQUEST : OP_LOAD;
        if ($urandom_range(9) == 0)
        begin
            slot = SLOT_W'($urandom);
        end
        else
        begin
            slot = SLOT_W'($urandom_range(0, (span + 3 < MAX_SLOTS) ? span + 3 : MAX_SLOTS - 1));
        end
        case ($urandom_range(11))
            0:       amt = '0;
            1:       amt = '1;
            2:       amt = AMT_W'($urandom);
            3:       amt = AMT_W'(1) << $urandom_range(AMT_W - 1);
            default: amt = (op == OP_LOAD) ? AMT_W'($urandom_range(40, 4000))
                                           : AMT_W'($urandom_range(1, 600));
        endcase
        send_beat(op, slot, amt);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.operation    = OP_LOAD;
        item_ch.slot_index   = '0;
        item_ch.amount       = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.active_slots  = ACTIVE_RESET;
        tx_idle_pct          = 34;
        rx_stall_pct         = 88;
        settings_used        = 0;
        cur_active           = ACTIVE_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty tree under the reset count: a zero amount fits the first slot.
        send_beat(OP_REQUEST, '0, '0);
        send_beat(OP_REQUEST, '0, AMT_W'(1));
        send_beat(OP_REQUEST, '1, '1);
        send_beat(OP_LOAD, '0, '1);
        send_beat(OP_LOAD, '1, AMT_W'(5));
        send_beat(OP_LOAD, SLOT_W'(511), AMT_W'(32'h8000_0000));
        send_beat(OP_REQUEST, '0, '1);
        send_beat(OP_REQUEST, '0, '0);
        send_beat(OP_REQUEST, '0, AMT_W'(6));
        send_beat(OP_REQUEST, '0, AMT_W'(32'h7FFF_FFFA));
        send_beat(OP_REQUEST, '0, AMT_W'(5));
        send_beat(OP_REQUEST, '0, AMT_W'(1));
        send_beat(OP_LOAD, SLOT_W'(10'h2AA), AMT_W'(32'h5555_5555));
        send_beat(OP_LOAD, SLOT_W'(10'h155), AMT_W'(32'hAAAA_AAAA));

        // No slot searched at all.
        wait_results(DRAIN_CYCLES);
        write_active('0);
        send_beat(OP_REQUEST, '0, '0);

        // Only slot 0 searched; a load beyond it is never granted.
        wait_results(DRAIN_CYCLES);
        write_active(ACTIVE_W'(1));
        send_beat(OP_REQUEST, '0, '0);
        send_beat(OP_LOAD, SLOT_W'(5), AMT_W'(100));
        send_beat(OP_REQUEST, '0, AMT_W'(50));

        // A count above the slot total searches every slot.
        wait_results(DRAIN_CYCLES);
        write_active('1);
        send_beat(OP_REQUEST, '0, AMT_W'(32'hAAAA_AAAA));
        send_beat(OP_REQUEST, '0, AMT_W'(32'h5555_5555));
        send_beat(OP_REQUEST, '0, AMT_W'(50));

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 34;
                    rx_stall_pct = 88;
                end
                1:
                begin
                    tx_idle_pct  = 88;
                    rx_stall_pct = 34;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                wait_results(DRAIN_CYCLES);
                write_active(pick_active());
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    // Halfway through, let the block run completely dry.
                    if (n == SEG_ITEMS / 2) wait_results(0);
                    send_random_item();
                end
            end
        end

        wait_results(DRAIN_CYCLES);
        $display("Covered %0d loads and %0d requests (%0d granted, %0d refused)",
                 loads_seen, grants_seen + refusals_seen, grants_seen, refusals_seen);
        $display("under %0d active-count settings and three idling patterns.", settings_used);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("max_tree_first_fit_allocator_top test passed");
        end
        else
        begin
            $display("max_tree_first_fit_allocator_top test failed");
        end
        $finish;
    end

    initial
    begin
        #(8_000_000);
        $display("max_tree_first_fit_allocator_top test failed");
        $finish;
    end

endmodule
